/* src/avbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avbd_pkg
// Shared types, constants and lookup functions for the averaging voltmeter
// with a two-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
package avbd_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int SEG_W    = 7;
    localparam int TENTHS_W = 6;
    localparam int DIGIT_W  = 4;

    // Group size default and queue depth between front and back
    localparam int DEF_SAMPLES_PER_MEAN = 8;
    localparam int Q_DEPTH              = 4;

    // Scaling: tenths = (mean * SCALE_MUL + SCALE_RND) / SCALE_DIV
    localparam int SCALE_MUL = 33;
    localparam int SCALE_RND = 511;
    localparam int SCALE_DIV = 1023;
    localparam int DIV_SH    = 10;   // SCALE_DIV = 2**DIV_SH - 1
    localparam int X_W       = 16;   // holds 1023*33+511
    localparam int MAX_TENTHS = 33;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SEG_W-1:0]    segments;
        logic                digit_select;
        logic [TENTHS_W-1:0] volt_tenths;
    } t_out_item;

    // Classified event passed from front to back
    typedef struct packed {
        logic                is_tick;
        logic [SAMPLE_W-1:0] sample;
    } t_evt;

    // Seven-segment code, bit0 = a ... bit6 = g
    function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] c;
        case (d)
            4'h0:    c = 7'h3F;
            4'h1:    c = 7'h06;
            4'h2:    c = 7'h5B;
            4'h3:    c = 7'h4F;
            4'h4:    c = 7'h66;
            4'h5:    c = 7'h6D;
            4'h6:    c = 7'h7D;
            4'h7:    c = 7'h07;
            4'h8:    c = 7'h7F;
            4'h9:    c = 7'h6F;
            4'hA:    c = 7'h77;
            4'hB:    c = 7'h7C;
            4'hC:    c = 7'h39;
            4'hD:    c = 7'h5E;
            4'hE:    c = 7'h79;
            default: c = 7'h71;
        endcase
        return c;
    endfunction

    // Tens digit of a 6-bit value by parallel compares
    function automatic logic [DIGIT_W-1:0] tens_of(input logic [TENTHS_W-1:0] t);
        logic [DIGIT_W-1:0] r;
        r = '0;
        for (int k = 1; k <= 6; k++) begin
            if (t >= TENTHS_W'(10 * k)) begin
                r = DIGIT_W'(k);
            end
        end
        return r;
    endfunction

    // Units digit given the tens digit
    function automatic logic [DIGIT_W-1:0] units_of(input logic [TENTHS_W-1:0] t,
                                                    input logic [DIGIT_W-1:0]  tens);
        logic [TENTHS_W-1:0] ten_x;
        logic [TENTHS_W-1:0] diff;
        ten_x = TENTHS_W'({tens, 3'b000}) + TENTHS_W'({tens, 1'b0});
        diff  = t - ten_x;
        return diff[DIGIT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* src/avbd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avbd_front
// Accepts input beats, classifies them as sample or refresh tick, and holds
// them in a short queue that the back end drains.
// ----------------------------------------------------------------------------
module avbd_front
    import avbd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_evt_valid,
    input  wire logic     i_evt_ready,
    output t_evt          o_evt
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_evt             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;
    t_evt             n_evt;

    // Classify the incoming beat; a tick carries no sample
    always_comb begin
        n_evt.is_tick = (i_in_data.cmd == CMD_TICK);
        n_evt.sample  = n_evt.is_tick ? '0 : i_in_data.sample;
    end

    assign o_in_ready  = (r_count != CNT_W'(Q_DEPTH));
    assign o_evt_valid = (r_count != '0);
    assign o_evt       = r_mem[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_evt_valid && i_evt_ready;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the classified beat
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= n_evt;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue occupancy above depth");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(Q_DEPTH)) && !pop |=> $stable(r_wr_ptr))
        else $error("write pointer moved while queue full");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) || (r_count == CNT_W'(Q_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers disagree with occupancy");

endmodule
`default_nettype wire

/* src/avbd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// avbd_back
// Executes queued events in order: accumulates samples, forms the scaled mean
// through a five-stage pipeline, and drives the display result register.
// ----------------------------------------------------------------------------
module avbd_back
    import avbd_pkg::*;
#(
    parameter int SAMPLES_PER_MEAN = DEF_SAMPLES_PER_MEAN
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_evt_valid,
    output logic       o_evt_ready,
    input  wire t_evt  i_evt,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_item  o_out_data
);

    localparam int N      = SAMPLES_PER_MEAN;
    localparam int SUM_W  = $clog2(N * ((1 << SAMPLE_W) - 1) + 1);
    localparam int CNT_W  = $clog2(N);
    localparam int PROD_W = 2 * SUM_W;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << SUM_W) / N);
    localparam int Q0_W   = X_W - DIV_SH;

    logic                en;
    logic                pop;

    // Stage 1: accumulator state and completed-group output
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    sum_add;
    logic                group_done;
    logic                r_s1_valid;
    logic                r_s1_tick;
    logic [SUM_W-1:0]    r_s1_sum;

    // Stage 2: reciprocal product
    logic                r_s2_valid;
    logic                r_s2_tick;
    logic [SUM_W-1:0]    r_s2_sum;
    logic [PROD_W-1:0]   r_s2_prod;

    // Stage 3: corrected mean
    logic [SUM_W-1:0]    q_est;
    logic [SUM_W-1:0]    rem;
    logic [SAMPLE_W-1:0] mean;
    logic                r_s3_valid;
    logic                r_s3_tick;
    logic [SAMPLE_W-1:0] r_s3_mean;

    // Stage 4: scaled numerator
    logic                r_s4_valid;
    logic                r_s4_tick;
    logic [X_W-1:0]      r_s4_x;

    // Stage 5: divide by 1023, store and display
    logic [Q0_W-1:0]     q0;
    logic [DIV_SH:0]     rr;
    logic [TENTHS_W-1:0] tenths;
    logic [TENTHS_W-1:0] r_stored;
    logic                r_high_next;
    logic [DIGIT_W-1:0]  tens;
    logic [DIGIT_W-1:0]  units;
    logic [SEG_W-1:0]    code;
    logic                r_out_valid;
    t_out_item           r_out;

    // Pipeline moves whenever the result register can take a beat
    assign en          = !r_out_valid || i_out_ready;
    assign o_evt_ready = en;
    assign pop         = i_evt_valid && en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Accumulate
    always_comb begin
        sum_add    = r_sum + SUM_W'(i_evt.sample);
        group_done = !i_evt.is_tick && (r_cnt == CNT_W'(N - 1));
    end

    // Correct the reciprocal estimate by one compare and subtract
    always_comb begin
        q_est = r_s2_prod[PROD_W-1:SUM_W];
        rem   = r_s2_sum - SUM_W'(q_est * SUM_W'(N));
        mean  = q_est[SAMPLE_W-1:0] + SAMPLE_W'(rem >= SUM_W'(N));
    end

    // Divide by 2**DIV_SH - 1: quotient of the shift, plus one if the
    // folded remainder reaches the divisor
    always_comb begin
        q0     = r_s4_x[X_W-1:DIV_SH];
        rr     = {1'b0, r_s4_x[DIV_SH-1:0]} + (DIV_SH + 1)'(q0);
        tenths = TENTHS_W'(q0) + TENTHS_W'(rr >= (DIV_SH + 1)'(SCALE_DIV));
    end

    // Select the digit to show
    always_comb begin
        tens  = tens_of(r_stored);
        units = units_of(r_stored, tens);
        code  = r_high_next ? seg_code(tens) : seg_code(units);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_stored    <= '0;
            r_high_next <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            if (pop && !i_evt.is_tick) begin
                if (group_done) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= sum_add;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            // Only ticks and group completions travel down the pipe
            r_s1_valid  <= pop && (i_evt.is_tick || group_done);
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid && r_s4_tick;
            if (r_s4_valid && !r_s4_tick) begin
                r_stored <= tenths;
            end
            if (r_s4_valid && r_s4_tick) begin
                r_high_next <= !r_high_next;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_tick <= i_evt.is_tick;
            r_s1_sum  <= sum_add;
            r_s2_tick <= r_s1_tick;
            r_s2_sum  <= r_s1_sum;
            r_s2_prod <= PROD_W'(r_s1_sum) * PROD_W'(RECIP);
            r_s3_tick <= r_s2_tick;
            r_s3_mean <= mean;
            r_s4_tick <= r_s3_tick;
            r_s4_x    <= X_W'(r_s3_mean) * X_W'(SCALE_MUL) + X_W'(SCALE_RND);
            if (r_s4_valid && r_s4_tick) begin
                r_out.segments     <= code;
                r_out.digit_select <= r_high_next;
                r_out.volt_tenths  <= r_stored;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(N - 1))
        else $error("sample count past group size");

    a_tenths_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= TENTHS_W'(MAX_TENTHS))
        else $error("stored voltage out of range");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_sum) && $stable(r_stored))
        else $error("back end advanced while result stalled");

    a_tick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_s4_valid && r_s4_tick |=> r_out_valid)
        else $error("tick left the pipe without a result");

endmodule
`default_nettype wire

/* src/adc_average_volt_bcd_display.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adc_average_volt_bcd_display
// Averages converter samples in groups, scales the mean to tenths of a volt
// and emits multiplexed seven-segment codes on display refresh ticks.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//
//  One beat per cycle unless the result stalls, set by the five-stage back pipeline.
//  A tick travels through the queue and the back pipeline to the result register.
//  Sample beats produce no result; reset clears the accumulator, the stored
//  value and the digit phase (units first), no clearing pass.
//  A stalled result freezes the back pipe; the 4-entry queue keeps taking
//  input beats until it fills.
// ----------------------------------------------------------------------------
module adc_average_volt_bcd_display
    import avbd_pkg::*;
#(
    parameter int SAMPLES_PER_MEAN = DEF_SAMPLES_PER_MEAN
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic evt_valid;
    logic evt_ready;
    t_evt evt;

    // Accept and queue
    avbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_evt_valid (evt_valid),
        .i_evt_ready (evt_ready),
        .o_evt       (evt)
    );

    // Execute and drive the display result
    avbd_back #(
        .SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .o_evt_ready (evt_ready),
        .i_evt       (evt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
